>>> hdl/slot_priority_queue_unit_defines.svh
// Assertion macros used by the slot priority queue checker
`ifndef SLOT_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SLOT_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SPPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define SPPQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> hdl/sppq_pkg.sv
// Types and constants of the slot priority queue
`timescale 1ns / 1ps
`default_nettype none
package sppq_pkg;

  localparam int unsigned PrioW  = 4;
  localparam int unsigned IdentW = 17;
  localparam int unsigned PidW   = 22;
  localparam int unsigned IndexW = 8;
  localparam int unsigned TimeW  = 3;
  localparam int unsigned OccW   = 4;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_POPPED   = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef struct packed {
    logic [TimeW-1:0]  run_time;
    logic [IndexW-1:0] owner_index;
    logic [PidW-1:0]   owner_pid;
    logic [IdentW-1:0] job_ident;
  } job_payload_t;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    job_payload_t     payload;
  } slot_entry_t;

  // Control from the sequencer to the best-slot tracker
  typedef struct packed {
    logic clr;
    logic chk;
  } cmp_ctrl_t;

endpackage
`default_nettype wire

>>> hdl/sppq_ram.sv
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps
`default_nettype none
module sppq_ram #(
  parameter int unsigned WIDTH = 54,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> hdl/sppq_best.sv
// Running maximum over the slots read during a pop scan
`timescale 1ns / 1ps
`default_nettype none
module sppq_best #(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire sppq_pkg::cmp_ctrl_t      ctrl_i,
  input  wire logic [$clog2(SLOTS)-1:0] cand_idx_i,
  input  wire logic                     cand_used_i,
  input  wire sppq_pkg::slot_entry_t    cand_i,
  output logic                          found_o,
  output logic      [$clog2(SLOTS)-1:0] best_idx_o,
  output sppq_pkg::slot_entry_t         best_o
);
  import sppq_pkg::*;

  localparam int unsigned IdxW = $clog2(SLOTS);

  logic            found_q, found_d;
  logic [IdxW-1:0] best_idx_q;
  slot_entry_t     best_q;
  logic            take;

  // Strictly greater keeps the lowest-numbered slot on ties
  assign take = ctrl_i.chk && cand_used_i && (!found_q || (cand_i.prio > best_q.prio));

  always_comb begin
    found_d = found_q;
    if (ctrl_i.clr) begin
      found_d = 1'b0;
    end else if (take) begin
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !ctrl_i.clr) begin
      best_idx_q <= cand_idx_i;
      best_q     <= cand_i;
    end
  end

  assign found_o    = found_q;
  assign best_idx_o = best_idx_q;
  assign best_o     = best_q;

endmodule
`default_nettype wire

>>> hdl/slot_priority_queue_unit.sv
// Top level of the slot priority queue: sequencer, slot valid bits and storage
`timescale 1ns / 1ps
`default_nettype none
// Priority queue over SLOTS job slots. An item is taken when start_i is high
// and busy_o is low; exactly one result follows, shown for one cycle with
// done_o high, and the receiver cannot hold it off. An insert walks the slot
// valid bits one per cycle up to the first free slot; a pop reads every slot
// from the slot RAM through its single read port, one per cycle, and feeds a
// single priority comparator. A full insert or an empty pop is answered
// without a scan of the slots. The next item may start in the cycle that
// done_o is high.
module slot_priority_queue_unit #(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        mode_i,
  input  wire logic [3:0]  job_priority_i,
  input  wire logic [16:0] job_ident_i,
  input  wire logic [21:0] owner_pid_i,
  input  wire logic [7:0]  owner_index_i,
  input  wire logic [2:0]  run_time_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [3:0]       out_priority_o,
  output logic [16:0]      out_job_ident_o,
  output logic [21:0]      out_owner_pid_o,
  output logic [7:0]       out_owner_index_o,
  output logic [2:0]       out_run_time_o,
  output logic [3:0]       occupancy_o
);
  import sppq_pkg::*;

  localparam int unsigned IdxW = $clog2(SLOTS);
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_POP,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] count_q, count_d;
  logic            used_q [SLOTS];
  logic            used_d [SLOTS];
  logic            chk_q, chk_d;
  logic [IdxW-1:0] chk_idx_q, chk_idx_d;
  logic            done_q, done_d;
  slot_entry_t     ins_q, ins_d;
  status_e         status_q, status_d;
  slot_entry_t     res_q, res_d;
  logic [OccW-1:0] occ_q, occ_d;

  logic            ram_we;
  logic            ram_re;
  slot_entry_t     ram_rdata;
  cmp_ctrl_t       cmp_ctrl;
  logic            best_found;
  logic [IdxW-1:0] best_idx;
  slot_entry_t     best;

  // Low four bits of a count, zero-extended when the count is narrower
  function automatic logic [OccW-1:0] occ_of(input logic [CntW-1:0] c);
    logic [CntW+OccW-1:0] ext;
    ext = {{OccW{1'b0}}, c};
    return ext[OccW-1:0];
  endfunction

  sppq_ram #(
    .WIDTH($bits(slot_entry_t)),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(ins_q),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  sppq_best #(
    .SLOTS(SLOTS)
  ) u_best (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (cmp_ctrl),
    .cand_idx_i (chk_idx_q),
    .cand_used_i(used_q[chk_idx_q]),
    .cand_i     (ram_rdata),
    .found_o    (best_found),
    .best_idx_o (best_idx),
    .best_o     (best)
  );

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    used_d    = used_q;
    chk_d     = 1'b0;
    chk_idx_d = idx_q;
    done_d    = 1'b0;
    ins_d     = ins_q;
    status_d  = status_q;
    res_d     = res_q;
    occ_d     = occ_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    cmp_ctrl  = '{clr: 1'b0, chk: chk_q};

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          idx_d                     = '0;
          cmp_ctrl.clr              = 1'b1;
          ins_d.prio                = job_priority_i;
          ins_d.payload.job_ident   = job_ident_i;
          ins_d.payload.owner_pid   = owner_pid_i;
          ins_d.payload.owner_index = owner_index_i;
          ins_d.payload.run_time    = run_time_i;
          state_d                   = mode_i ? S_POP : S_INS;
        end
      end
      S_INS: begin
        if (count_q == CntW'(SLOTS)) begin
          status_d = ST_FULL;
          res_d    = '0;
          occ_d    = occ_of(count_q);
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else if (!used_q[idx_q]) begin
          ram_we         = 1'b1;
          used_d[idx_q]  = 1'b1;
          count_d        = count_q + 1'b1;
          status_d       = ST_INSERTED;
          res_d          = '0;
          occ_d          = occ_of(count_q + 1'b1);
          done_d         = 1'b1;
          state_d        = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_POP: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
          res_d    = '0;
          occ_d    = occ_of(count_q);
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          // Issue a read; the compare follows in the next cycle
          ram_re    = 1'b1;
          chk_d     = 1'b1;
          chk_idx_d = idx_q;
          if (idx_q == IdxW'(SLOTS - 1)) begin
            state_d = S_DRAIN;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        // A pop only gets here with a slot in use, so the tracker has a winner
        if (best_found) begin
          used_d[best_idx] = 1'b0;
        end
        count_d          = count_q - 1'b1;
        status_d         = ST_POPPED;
        res_d            = best;
        occ_d            = occ_of(count_q - 1'b1);
        done_d           = 1'b1;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      count_q   <= '0;
      used_q    <= '{default: 1'b0};
      chk_q     <= 1'b0;
      chk_idx_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      count_q   <= count_d;
      used_q    <= used_d;
      chk_q     <= chk_d;
      chk_idx_q <= chk_idx_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_q    <= ins_d;
    status_q <= status_d;
    res_q    <= res_d;
    occ_q    <= occ_d;
  end

  assign busy_o            = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign status_o          = status_q;
  assign out_priority_o    = res_q.prio;
  assign out_job_ident_o   = res_q.payload.job_ident;
  assign out_owner_pid_o   = res_q.payload.owner_pid;
  assign out_owner_index_o = res_q.payload.owner_index;
  assign out_run_time_o    = res_q.payload.run_time;
  assign occupancy_o       = occ_q;

endmodule
`default_nettype wire

>>> hdl/sppq_checker.sv
// Port-level checks of the slot priority queue, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "slot_priority_queue_unit_defines.svh"
module sppq_checker #(
  parameter int unsigned SLOTS = 8
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        done_o,
  input wire logic [1:0]  status_o,
  input wire logic [3:0]  out_priority_o,
  input wire logic [16:0] out_job_ident_o,
  input wire logic [21:0] out_owner_pid_o,
  input wire logic [7:0]  out_owner_index_o,
  input wire logic [2:0]  out_run_time_o,
  input wire logic [3:0]  occupancy_o
);
  import sppq_pkg::*;

  localparam logic [3:0] FullOcc = 4'(SLOTS);

  // An accepted item keeps the block busy until its result
  `SPPQ_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  // A result is never shown twice in a row
  `SPPQ_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  // Results other than a pop (inserted, refused or empty) carry no job
  `SPPQ_ASSERT_IMP(a_no_job, clk_i, rst_ni,
    done_o && (status_o != ST_POPPED),
    (out_priority_o == 4'd0) && (out_job_ident_o == 17'd0) &&
    (out_owner_pid_o == 22'd0) && (out_owner_index_o == 8'd0) &&
    (out_run_time_o == 3'd0))
  // Empty pop reports no occupancy, full insert reports a full store
  `SPPQ_ASSERT_IMP(a_occ_edge, clk_i, rst_ni,
    done_o && ((status_o == ST_EMPTY) || (status_o == ST_FULL)),
    ((status_o == ST_EMPTY) && (occupancy_o == 4'd0)) ||
    ((status_o == ST_FULL) && (occupancy_o == FullOcc)))

endmodule

bind slot_priority_queue_unit sppq_checker #(
  .SLOTS(SLOTS)
) u_sppq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .done_o           (done_o),
  .status_o         (status_o),
  .out_priority_o   (out_priority_o),
  .out_job_ident_o  (out_job_ident_o),
  .out_owner_pid_o  (out_owner_pid_o),
  .out_owner_index_o(out_owner_index_o),
  .out_run_time_o   (out_run_time_o),
  .occupancy_o      (occupancy_o)
);
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the slot priority queue unit
`timescale 1ns / 1ps
module testbench;
  import sppq_pkg::*;

  localparam int unsigned SLOTS       = 8;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic        MODE_INSERT = 1'b0;
  localparam logic        MODE_POP    = 1'b1;

  typedef struct packed {
    status_e          status;
    logic [PrioW-1:0] prio;
    job_payload_t     job;
    logic [OccW-1:0]  occupancy;
  } queue_answer_t;

  // Slot store mirror and the answers still owed by the block
  class pop_order_scoreboard;
    bit               slot_taken [SLOTS];
    logic [PrioW-1:0] slot_prio  [SLOTS];
    job_payload_t     slot_job   [SLOTS];
    int unsigned      taken_count;
    queue_answer_t    awaited_answers [$];
    int unsigned      mismatch_count;
    int unsigned      items_noted;
    int unsigned      status_seen [4];

    function void flag(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t: mismatch: %s", $time, msg);
      end
    endfunction

    function queue_answer_t predict_queue_step(logic mode, logic [PrioW-1:0] prio,
                                               job_payload_t job);
      queue_answer_t ans;
      int            pick;
      ans  = '0;
      pick = -1;
      if (mode == MODE_INSERT) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_taken[i] && pick < 0) pick = i;
        end
        if (pick < 0) begin
          ans.status = ST_FULL;
        end else begin
          slot_taken[pick] = 1'b1;
          slot_prio[pick]  = prio;
          slot_job[pick]   = job;
          taken_count++;
          ans.status = ST_INSERTED;
        end
      end else begin
        // strict greater-than keeps the lowest slot on a tie
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_taken[i] && (pick < 0 || slot_prio[i] > slot_prio[pick])) pick = i;
        end
        if (pick < 0) begin
          ans.status = ST_EMPTY;
        end else begin
          ans.status       = ST_POPPED;
          ans.prio         = slot_prio[pick];
          ans.job          = slot_job[pick];
          slot_taken[pick] = 1'b0;
          taken_count--;
        end
      end
      ans.occupancy = taken_count[OccW-1:0];
      return ans;
    endfunction

    function void note_item(logic mode, logic [PrioW-1:0] prio, job_payload_t job);
      awaited_answers.push_back(predict_queue_step(mode, prio, job));
      items_noted++;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) flag($sformatf("%s expected 'h%0h, got 'h%0h", name, want, got));
    endfunction

    function void check_result(queue_answer_t got);
      queue_answer_t want;
      if (awaited_answers.size() == 0) begin
        flag($sformatf("result with status %0d while nothing is awaited", got.status));
        return;
      end
      want = awaited_answers.pop_front();
      status_seen[want.status]++;
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("out_priority", 32'(want.prio), 32'(got.prio));
      compare_field("out_job_ident", 32'(want.job.job_ident), 32'(got.job.job_ident));
      compare_field("out_owner_pid", 32'(want.job.owner_pid), 32'(got.job.owner_pid));
      compare_field("out_owner_index", 32'(want.job.owner_index),
                    32'(got.job.owner_index));
      compare_field("out_run_time", 32'(want.job.run_time), 32'(got.job.run_time));
      compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
    endfunction

    function int unsigned pending();
      return awaited_answers.size();
    endfunction

    function void check_leftovers();
      if (awaited_answers.size() != 0) begin
        flag($sformatf("%0d results never arrived", awaited_answers.size()));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        mode;
  logic [3:0]  job_priority;
  logic [16:0] job_ident;
  logic [21:0] owner_pid;
  logic [7:0]  owner_index;
  logic [2:0]  run_time;
  logic        done;
  logic [1:0]  status;
  logic [3:0]  out_priority;
  logic [16:0] out_job_ident;
  logic [21:0] out_owner_pid;
  logic [7:0]  out_owner_index;
  logic [2:0]  out_run_time;
  logic [3:0]  occupancy;

  pop_order_scoreboard sb;

  slot_priority_queue_unit #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_o           (busy),
    .mode_i           (mode),
    .job_priority_i   (job_priority),
    .job_ident_i      (job_ident),
    .owner_pid_i      (owner_pid),
    .owner_index_i    (owner_index),
    .run_time_i       (run_time),
    .done_o           (done),
    .status_o         (status),
    .out_priority_o   (out_priority),
    .out_job_ident_o  (out_job_ident),
    .out_owner_pid_o  (out_owner_pid),
    .out_owner_index_o(out_owner_index),
    .out_run_time_o   (out_run_time),
    .occupancy_o      (occupancy)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check results before noting a new item; both follow arrival order
  always @(posedge clk) begin
    queue_answer_t got;
    job_payload_t  in_job;
    if (rst_n) begin
      if (done) begin
        got.status           = status_e'(status);
        got.prio             = out_priority;
        got.job.job_ident    = out_job_ident;
        got.job.owner_pid    = out_owner_pid;
        got.job.owner_index  = out_owner_index;
        got.job.run_time     = out_run_time;
        got.occupancy        = occupancy;
        sb.check_result(got);
      end
      if (start && !busy) begin
        in_job.job_ident   = job_ident;
        in_job.owner_pid   = owner_pid;
        in_job.owner_index = owner_index;
        in_job.run_time    = run_time;
        sb.note_item(mode, job_priority, in_job);
      end
    end
  end

  task automatic send_item(input logic m, input logic [3:0] p, input logic [16:0] id,
                           input logic [21:0] pid, input logic [7:0] idx,
                           input logic [2:0] rt);
    @(negedge clk);
    start        <= 1'b1;
    mode         <= m;
    job_priority <= p;
    job_ident    <= id;
    owner_pid    <= pid;
    owner_index  <= idx;
    run_time     <= rt;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_cycle();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Hold off new items until every owed result is back
  task automatic drain();
    idle_cycle();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_item(int unsigned insert_pct);
    logic       m;
    logic [3:0] p;
    m = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_POP;
    // narrow priority ranges make ties common
    case ($urandom_range(0, 3))
      0, 1:    p = 4'($urandom_range(0, 15));
      2:       p = 4'($urandom_range(0, 1));
      default: p = 4'hF;
    endcase
    send_item(m, p, 17'($urandom), 22'($urandom), 8'($urandom), 3'($urandom));
  endtask

  initial begin
    int unsigned idle_pct [4];
    int unsigned insert_pct;
    sb           = new;
    rst_n        = 1'b0;
    start        = 1'b0;
    mode         = MODE_INSERT;
    job_priority = '0;
    job_ident    = '0;
    owner_pid    = '0;
    owner_index  = '0;
    run_time     = '0;
    idle_pct     = '{0, 75, 0, 34};
    insert_pct   = 50;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // pop on empty, fill to the brim with extreme fields and ties, refuse, empty out
    send_item(MODE_POP, 4'hF, 17'h1FFFF, 22'h3FFFFF, 8'hFF, 3'h7);
    send_item(MODE_INSERT, 4'h0, 17'h00000, 22'h000000, 8'h00, 3'h0);
    send_item(MODE_INSERT, 4'hF, 17'h1FFFF, 22'h3FFFFF, 8'hFF, 3'h7);
    send_item(MODE_INSERT, 4'h7, 17'h0AAAA, 22'h155555, 8'h55, 3'h5);
    send_item(MODE_INSERT, 4'hF, 17'h15555, 22'h2AAAAA, 8'hAA, 3'h2);
    send_item(MODE_INSERT, 4'h0, 17'h00001, 22'h000001, 8'h01, 3'h1);
    send_item(MODE_INSERT, 4'h3, 17'h10000, 22'h200000, 8'h80, 3'h4);
    send_item(MODE_INSERT, 4'hF, 17'h0FFFF, 22'h1FFFFF, 8'h7F, 3'h3);
    send_item(MODE_INSERT, 4'h8, 17'h12345, 22'h0ABCDE, 8'h3C, 3'h6);
    send_item(MODE_INSERT, 4'h9, 17'h1FFFF, 22'h3FFFFF, 8'hFF, 3'h7);
    repeat (SLOTS) send_item(MODE_POP, 4'h0, 17'h0, 22'h0, 8'h0, 3'h0);
    send_item(MODE_POP, 4'h0, 17'h0, 22'h0, 8'h0, 3'h0);
    send_item(MODE_INSERT, 4'h0, 17'h1FFFF, 22'h3FFFFF, 8'hFF, 3'h7);
    send_item(MODE_POP, 4'hF, 17'h0, 22'h0, 8'h0, 3'h0);
    drain();

    // sender idling per phase; the receiver cannot stall, so it never does
    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < 125; n++) begin
        // swing the insert share so the queue runs full and empty in turn
        if (n % 20 == 0) begin
          case ($urandom_range(0, 2))
            0:       insert_pct = 85;
            1:       insert_pct = 50;
            default: insert_pct = 15;
          endcase
        end
        while ($urandom_range(0, 99) < idle_pct[phase]) idle_cycle();
        random_item(insert_pct);
        if ($urandom_range(0, 29) == 0) drain();
      end
      drain();
    end

    repeat (SLOTS + 4) @(posedge clk);
    sb.check_leftovers();
    $display("Run covered %0d items: %0d inserts, %0d pops, %0d refused as full, %0d empty pops",
             sb.items_noted, sb.status_seen[ST_INSERTED], sb.status_seen[ST_POPPED],
             sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY]);
    $display("Mismatches counted: %0d", sb.mismatch_count);
    if (sb.mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/sppq_pkg.sv
hdl/sppq_ram.sv
hdl/sppq_best.sv
hdl/slot_priority_queue_unit.sv
hdl/sppq_checker.sv
tb/testbench.sv
